// ===== src/line_segment_clip_assert.svh =====
// Assertion macros for the line segment clipper.
`ifndef LINE_SEGMENT_CLIP_ASSERT_SVH
`define LINE_SEGMENT_CLIP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lsc_pkg.sv =====
// Shared constants for the line segment clipper.
package lsc_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Window reset values
  localparam int WIN_LEFT_RST   = 200;
  localparam int WIN_RIGHT_RST  = 400;
  localparam int WIN_TOP_RST    = 200;
  localparam int WIN_BOTTOM_RST = 400;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // Region code bits
  localparam logic [3:0] CODE_LEFT  = 4'd1;
  localparam logic [3:0] CODE_RIGHT = 4'd2;
  localparam logic [3:0] CODE_BELOW = 4'd4;
  localparam logic [3:0] CODE_ABOVE = 4'd8;

endpackage

// ===== src/line_segment_clip.sv =====
// Line segment clipper: region codes and endpoint clipping against a register window.
// Usage: write the window (left, right, top, bottom) over the APB port at byte
// addresses 0, 4, 8 and 12 while no segment is in flight; reads return the values.
// Input beats on in_* carry one segment (x_start, y_start, x_end, y_end); every
// segment yields exactly one output beat on out_*: the clipped endpoints, the
// region codes of the original endpoints, and a visible flag in out_tuser.
// Rejected segments come out with visible low and all clipped coordinates zero.
// Stages: one for region codes, then two multiply/divide pipelines in series
// (horizontal edge, then vertical edge) with a register between them that picks
// the vertical edge, each pipeline COORD_BITS + 3 deep with one quotient bit per
// stage, then one output register. One segment enters every cycle unless stalled.
// A synchronous reset clears all valid bits and loads the default window
// 200..400 in both axes. When the receiver stalls, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated.
module line_segment_clip #(
  parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_start, y_start, x_end, y_end
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // clip_x_start, clip_y_start, clip_x_end, clip_y_end, region_start, region_end
  output logic [((4*COORD_BITS+15)/8)*8-1:0]   out_tdata,
  // visible
  output logic                                 out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [3:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int W     = COORD_BITS;
  localparam int OUT_DW = ((4*W+15)/8)*8;
  localparam int SB_HS = 4*W + 4;
  localparam int SB_HE = 4;
  localparam int SB_VS = (W+2) + W + 1 + W + 1 + 4 + 4 + 1;
  localparam int SB_VE = (W+2) + W + 1 + W + 1;

  // ---------------- configuration ----------------
  logic signed [W-1:0] win_left_r, win_right_r, win_top_r, win_bottom_r;
  logic [W-1:0]        rd_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= W'(lsc_pkg::WIN_LEFT_RST);
      win_right_r  <= W'(lsc_pkg::WIN_RIGHT_RST);
      win_top_r    <= W'(lsc_pkg::WIN_TOP_RST);
      win_bottom_r <= W'(lsc_pkg::WIN_BOTTOM_RST);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        lsc_pkg::REG_LEFT:   win_left_r   <= cfg_pwdata[W-1:0];
        lsc_pkg::REG_RIGHT:  win_right_r  <= cfg_pwdata[W-1:0];
        lsc_pkg::REG_TOP:    win_top_r    <= cfg_pwdata[W-1:0];
        lsc_pkg::REG_BOTTOM: win_bottom_r <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      lsc_pkg::REG_LEFT:   rd_val = win_left_r;
      lsc_pkg::REG_RIGHT:  rd_val = win_right_r;
      lsc_pkg::REG_TOP:    rd_val = win_top_r;
      lsc_pkg::REG_BOTTOM: rd_val = win_bottom_r;
      default:             rd_val = win_left_r;
    endcase
  end

  assign cfg_prdata = {{(32-W){rd_val[W-1]}}, rd_val};
  assign cfg_pready = 1'b1;

  // ---------------- helpers ----------------
  function automatic logic [3:0] region(
    input logic signed [W-1:0] x, input logic signed [W-1:0] y,
    input logic signed [W-1:0] l, input logic signed [W-1:0] r,
    input logic signed [W-1:0] t, input logic signed [W-1:0] b);
    logic [3:0] c;
    c = '0;
    if (x < l) c = c | lsc_pkg::CODE_LEFT;
    if (x > r) c = c | lsc_pkg::CODE_RIGHT;
    if (y > b) c = c | lsc_pkg::CODE_BELOW;
    if (y < t) c = c | lsc_pkg::CODE_ABOVE;
    return c;
  endfunction

  function automatic logic signed [W:0] sub1(
    input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic signed [W:0] aw, bw;
    aw = {a[W-1], a};
    bw = {b[W-1], b};
    return aw - bw;
  endfunction

  function automatic logic signed [W+1:0] ext2(input logic signed [W-1:0] a);
    return {{2{a[W-1]}}, a};
  endfunction

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: region codes ----------------
  logic signed [W-1:0] in_xs, in_ys, in_xe, in_ye;
  assign in_xs = in_tdata[W-1:0];
  assign in_ys = in_tdata[2*W-1:W];
  assign in_xe = in_tdata[3*W-1:2*W];
  assign in_ye = in_tdata[4*W-1:3*W];

  logic                p1_v_r;
  logic signed [W-1:0] p1_xs_r, p1_ys_r, p1_xe_r, p1_ye_r;
  logic [3:0]          p1_cs_r, p1_ce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_xs_r <= in_xs;
      p1_ys_r <= in_ys;
      p1_xe_r <= in_xe;
      p1_ye_r <= in_ye;
      p1_cs_r <= region(in_xs, in_ys, win_left_r, win_right_r, win_top_r, win_bottom_r);
      p1_ce_r <= region(in_xe, in_ye, win_left_r, win_right_r, win_top_r, win_bottom_r);
    end
  end

  // ---------------- horizontal edge crossing ----------------
  logic signed [W-1:0] hedg_s, hedg_e;
  assign hedg_s = (p1_cs_r & lsc_pkg::CODE_ABOVE) != '0 ? win_top_r : win_bottom_r;
  assign hedg_e = (p1_ce_r & lsc_pkg::CODE_ABOVE) != '0 ? win_top_r : win_bottom_r;

  logic                hs_v, he_v, hs_dz, he_dz;
  logic signed [W+1:0] hs_res, he_res;
  logic [SB_HS-1:0]    hs_sb;
  logic [SB_HE-1:0]    he_sb;

  lsc_lerp #(.W(W), .SBW(SB_HS)) u_hlerp_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p1_v_r),
    .base(p1_xs_r), .num(sub1(hedg_s, p1_ys_r)), .mul(sub1(p1_xe_r, p1_xs_r)),
    .den(sub1(p1_ye_r, p1_ys_r)),
    .sb_in({p1_cs_r, p1_ye_r, p1_xe_r, p1_ys_r, p1_xs_r}),
    .out_valid(hs_v), .res(hs_res), .dz(hs_dz), .sb_out(hs_sb)
  );

  lsc_lerp #(.W(W), .SBW(SB_HE)) u_hlerp_e (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p1_v_r),
    .base(p1_xe_r), .num(sub1(hedg_e, p1_ye_r)), .mul(sub1(p1_xs_r, p1_xe_r)),
    .den(sub1(p1_ys_r, p1_ye_r)),
    .sb_in(p1_ce_r),
    .out_valid(he_v), .res(he_res), .dz(he_dz), .sb_out(he_sb)
  );

  // ---------------- stage 2: pick vertical edge ----------------
  logic signed [W-1:0] h_xs, h_ys, h_xe, h_ye, hedg2_s, hedg2_e;
  logic [3:0]          h_cs, h_ce;
  logic                hneed_s, hneed_e;
  logic signed [W+1:0] xw_s, xw_e, lw, rw;
  logic signed [W-1:0] yw_s, yw_e;

  assign h_xs = hs_sb[W-1:0];
  assign h_ys = hs_sb[2*W-1:W];
  assign h_xe = hs_sb[3*W-1:2*W];
  assign h_ye = hs_sb[4*W-1:3*W];
  assign h_cs = hs_sb[4*W+3:4*W];
  assign h_ce = he_sb;

  assign hneed_s = (h_cs & (lsc_pkg::CODE_ABOVE | lsc_pkg::CODE_BELOW)) != '0;
  assign hneed_e = (h_ce & (lsc_pkg::CODE_ABOVE | lsc_pkg::CODE_BELOW)) != '0;
  assign hedg2_s = (h_cs & lsc_pkg::CODE_ABOVE) != '0 ? win_top_r : win_bottom_r;
  assign hedg2_e = (h_ce & lsc_pkg::CODE_ABOVE) != '0 ? win_top_r : win_bottom_r;

  assign lw   = ext2(win_left_r);
  assign rw   = ext2(win_right_r);
  assign xw_s = hneed_s ? hs_res : ext2(h_xs);
  assign xw_e = hneed_e ? he_res : ext2(h_xe);
  assign yw_s = hneed_s ? hedg2_s : h_ys;
  assign yw_e = hneed_e ? hedg2_e : h_ye;

  logic                p2_v_r, p2_rej_r;
  logic signed [W+1:0] p2_xw_s_r, p2_xw_e_r;
  logic signed [W-1:0] p2_yw_s_r, p2_yw_e_r, p2_vedg_s_r, p2_vedg_e_r;
  logic signed [W-1:0] p2_xs_r, p2_ys_r, p2_xe_r, p2_ye_r;
  logic                p2_vneed_s_r, p2_vneed_e_r, p2_fail_s_r, p2_fail_e_r;
  logic [3:0]          p2_cs_r, p2_ce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= hs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_xw_s_r    <= xw_s;
      p2_xw_e_r    <= xw_e;
      p2_yw_s_r    <= yw_s;
      p2_yw_e_r    <= yw_e;
      p2_vneed_s_r <= (h_cs != '0) && (xw_s < lw || xw_s > rw);
      p2_vneed_e_r <= (h_ce != '0) && (xw_e < lw || xw_e > rw);
      p2_vedg_s_r  <= (xw_s < lw) ? win_left_r : win_right_r;
      p2_vedg_e_r  <= (xw_e < lw) ? win_left_r : win_right_r;
      p2_fail_s_r  <= hneed_s && hs_dz;
      p2_fail_e_r  <= hneed_e && he_dz;
      p2_rej_r     <= (h_cs & h_ce) != '0;
      p2_cs_r      <= h_cs;
      p2_ce_r      <= h_ce;
      p2_xs_r      <= h_xs;
      p2_ys_r      <= h_ys;
      p2_xe_r      <= h_xe;
      p2_ye_r      <= h_ye;
    end
  end

  // ---------------- vertical edge crossing ----------------
  logic                vs_v, ve_v, vs_dz, ve_dz;
  logic signed [W+1:0] vs_res, ve_res;
  logic [SB_VS-1:0]    vs_sb;
  logic [SB_VE-1:0]    ve_sb;

  lsc_lerp #(.W(W), .SBW(SB_VS)) u_vlerp_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p2_v_r),
    .base(p2_ys_r), .num(sub1(p2_vedg_s_r, p2_xs_r)), .mul(sub1(p2_ye_r, p2_ys_r)),
    .den(sub1(p2_xe_r, p2_xs_r)),
    .sb_in({p2_rej_r, p2_ce_r, p2_cs_r, p2_fail_s_r, p2_vedg_s_r, p2_vneed_s_r,
            p2_yw_s_r, p2_xw_s_r}),
    .out_valid(vs_v), .res(vs_res), .dz(vs_dz), .sb_out(vs_sb)
  );

  lsc_lerp #(.W(W), .SBW(SB_VE)) u_vlerp_e (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p2_v_r),
    .base(p2_ye_r), .num(sub1(p2_vedg_e_r, p2_xe_r)), .mul(sub1(p2_ys_r, p2_ye_r)),
    .den(sub1(p2_xs_r, p2_xe_r)),
    .sb_in({p2_fail_e_r, p2_vedg_e_r, p2_vneed_e_r, p2_yw_e_r, p2_xw_e_r}),
    .out_valid(ve_v), .res(ve_res), .dz(ve_dz), .sb_out(ve_sb)
  );

  // ---------------- final inside test ----------------
  logic signed [W+1:0] v_xw_s, v_xw_e, fx_s, fy_s, fx_e, fy_e, tw, bw;
  logic signed [W-1:0] v_yw_s, v_yw_e, v_edg_s, v_edg_e;
  logic                v_need_s, v_need_e, v_fail_s, v_fail_e, v_rej;
  logic [3:0]          v_cs, v_ce;
  logic                in_s, in_e, ok;
  logic [OUT_DW-1:0]   res_data;

  assign v_xw_s   = vs_sb[W+1:0];
  assign v_yw_s   = vs_sb[2*W+1:W+2];
  assign v_need_s = vs_sb[2*W+2];
  assign v_edg_s  = vs_sb[3*W+2:2*W+3];
  assign v_fail_s = vs_sb[3*W+3];
  assign v_cs     = vs_sb[3*W+7:3*W+4];
  assign v_ce     = vs_sb[3*W+11:3*W+8];
  assign v_rej    = vs_sb[3*W+12];
  assign v_xw_e   = ve_sb[W+1:0];
  assign v_yw_e   = ve_sb[2*W+1:W+2];
  assign v_need_e = ve_sb[2*W+2];
  assign v_edg_e  = ve_sb[3*W+2:2*W+3];
  assign v_fail_e = ve_sb[3*W+3];

  assign tw   = ext2(win_top_r);
  assign bw   = ext2(win_bottom_r);
  assign fx_s = v_need_s ? ext2(v_edg_s) : v_xw_s;
  assign fy_s = v_need_s ? vs_res : ext2(v_yw_s);
  assign fx_e = v_need_e ? ext2(v_edg_e) : v_xw_e;
  assign fy_e = v_need_e ? ve_res : ext2(v_yw_e);
  assign in_s = fx_s >= lw && fx_s <= rw && fy_s >= tw && fy_s <= bw;
  assign in_e = fx_e >= lw && fx_e <= rw && fy_e >= tw && fy_e <= bw;
  assign ok   = !v_rej && !(v_fail_s || (v_need_s && vs_dz)) &&
                !(v_fail_e || (v_need_e && ve_dz)) && in_s && in_e;

  always_comb begin
    res_data = '0;
    res_data[4*W+7:0] = {v_ce, v_cs,
                         ok ? fy_e[W-1:0] : '0, ok ? fx_e[W-1:0] : '0,
                         ok ? fy_s[W-1:0] : '0, ok ? fx_s[W-1:0] : '0};
  end

  logic              out_v_r, out_vis_r;
  logic [OUT_DW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= vs_v && ve_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_data;
      out_vis_r  <= ok;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_vis_r;

  // ---------------- assertions ----------------
`include "line_segment_clip_assert.svh"

  `LSC_ASSERT_IMP(a_reject_zero, out_tvalid && !out_tuser, out_tdata[4*W-1:0] == '0, "rejected beat carries nonzero coordinates")
  `LSC_ASSERT_IMP(a_visible_codes, out_tvalid && out_tuser, (out_tdata[4*W+3:4*W] & out_tdata[4*W+7:4*W+4]) == '0, "visible segment with shared region bit")
  `LSC_ASSERT_NXT(a_stall_hold, !adv, $stable(p1_v_r) && $stable(p2_v_r), "pipeline moved during stall")
  `LSC_ASSERT_IMP(a_lane_sync, 1'b1, (vs_v == ve_v) && (hs_v == he_v), "endpoint lanes out of step")

endmodule

// ===== src/lsc_lerp.sv =====
// Pipelined base + trunc(num * mul / den): one multiply stage, one quotient bit per stage.
module lsc_lerp #(
  parameter int W   = lsc_pkg::COORD_BITS_DEF,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] base,
  input  logic signed [W:0]   num,
  input  logic signed [W:0]   mul,
  input  logic signed [W:0]   den,
  input  logic [SBW-1:0]      sb_in,
  output logic                out_valid,
  output logic signed [W+1:0] res,
  output logic                dz,
  output logic [SBW-1:0]      sb_out
);

  localparam int N  = W + 1;
  localparam int PW = 2 * N;

  logic [N-1:0]  num_mag, mul_mag, den_mag;
  logic [PW-1:0] prod;
  logic          neg;

  // Stage arrays: index 0 holds the product, index k the state after k quotient bits
  logic [N-1:0]   rem_r  [0:N];
  logic [N-1:0]   low_r  [0:N];
  logic [N-1:0]   dv_r   [0:N];
  logic           neg_r  [0:N];
  logic           dz_r   [0:N];
  logic [W-1:0]   base_r [0:N];
  logic [SBW-1:0] sb_r   [0:N];
  logic           v_r    [0:N];

  logic signed [W+1:0] res_r;
  logic                res_dz_r;
  logic [SBW-1:0]      res_sb_r;
  logic                res_v_r;
  logic signed [W+1:0] base_w, q_w;

  assign num_mag = num[N-1] ? N'(-num) : N'(num);
  assign mul_mag = mul[N-1] ? N'(-mul) : N'(mul);
  assign den_mag = den[N-1] ? N'(-den) : N'(den);
  assign prod    = PW'(num_mag) * PW'(mul_mag);
  assign neg     = (num[N-1] ^ mul[N-1]) ^ den[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= prod[PW-1:N];
      low_r[0]  <= prod[N-1:0];
      dv_r[0]   <= den_mag;
      neg_r[0]  <= neg;
      dz_r[0]   <= (den_mag == '0);
      base_r[0] <= base;
      sb_r[0]   <= sb_in;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]   trial;
    logic         ge;
    logic [N:0]   diff;
    logic [N-1:0] rem_nxt, low_nxt;

    always_comb begin
      trial   = {rem_r[k], low_r[k][N-1]};
      diff    = trial - {1'b0, dv_r[k]};
      ge      = (trial >= {1'b0, dv_r[k]});
      rem_nxt = ge ? diff[N-1:0] : trial[N-1:0];
      low_nxt = {low_r[k][N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        low_r[k+1]  <= low_nxt;
        dv_r[k+1]   <= dv_r[k];
        neg_r[k+1]  <= neg_r[k];
        dz_r[k+1]   <= dz_r[k];
        base_r[k+1] <= base_r[k];
        sb_r[k+1]   <= sb_r[k];
      end
    end
  end

  assign base_w = {{2{base_r[N][W-1]}}, base_r[N]};
  assign q_w    = {1'b0, low_r[N]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (en) begin
      res_v_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= neg_r[N] ? (base_w - q_w) : (base_w + q_w);
      res_dz_r <= dz_r[N];
      res_sb_r <= sb_r[N];
    end
  end

  assign out_valid = res_v_r;
  assign res       = res_r;
  assign dz        = res_dz_r;
  assign sb_out    = res_sb_r;

endmodule

// ===== tb/sv/line_segment_clip_checker.sv =====
// Checker for the line segment clipper: tracks the window, predicts each segment, compares.
module line_segment_clip_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        visible;
    logic [11:0] cxs, cys, cxe, cye;
    logic [3:0]  rs, re;
  } clip_result_t;

  clip_result_t clipped_q[$];
  longint win_l, win_r, win_t, win_b;

  initial pending = 0;

  function automatic longint sx12(logic [11:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [3:0] zone(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_l) c |= lsc_pkg::CODE_LEFT;
    if (x > win_r) c |= lsc_pkg::CODE_RIGHT;
    if (y > win_b) c |= lsc_pkg::CODE_BELOW;
    if (y < win_t) c |= lsc_pkg::CODE_ABOVE;
    return c;
  endfunction

  // move one endpoint toward the other; returns 1 if it lands inside the window
  function automatic bit move_end(longint x0, longint y0, longint x1, longint y1,
                                  logic [3:0] code, output longint ox, output longint oy);
    longint x, y, e;
    x = x0;
    y = y0;
    ox = 0;
    oy = 0;
    if ((code & (lsc_pkg::CODE_ABOVE | lsc_pkg::CODE_BELOW)) != 0) begin
      e = ((code & lsc_pkg::CODE_ABOVE) != 0) ? win_t : win_b;
      if (y1 == y0) return 0;
      x = x0 + ((e - y0) * (x1 - x0)) / (y1 - y0);
      y = e;
    end
    if (code != 0 && (x < win_l || x > win_r)) begin
      e = (x < win_l) ? win_l : win_r;
      if (x1 == x0) return 0;
      y = y0 + ((e - x0) * (y1 - y0)) / (x1 - x0);
      x = e;
    end
    ox = x;
    oy = y;
    return x >= win_l && x <= win_r && y >= win_t && y <= win_b;
  endfunction

  function automatic clip_result_t clip_segment(logic [47:0] d);
    clip_result_t res;
    longint xs, ys, xe, ye, axs, ays, axe, aye;
    bit ok;
    xs = sx12(d[11:0]);
    ys = sx12(d[23:12]);
    xe = sx12(d[35:24]);
    ye = sx12(d[47:36]);
    res.rs = zone(xs, ys);
    res.re = zone(xe, ye);
    ok = (res.rs & res.re) == 0;
    if (ok) ok = move_end(xs, ys, xe, ye, res.rs, axs, ays);
    if (ok) ok = move_end(xe, ye, xs, ys, res.re, axe, aye);
    res.visible = ok;
    res.cxs = ok ? axs[11:0] : '0;
    res.cys = ok ? ays[11:0] : '0;
    res.cxe = ok ? axe[11:0] : '0;
    res.cye = ok ? aye[11:0] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    clip_result_t want, got;
    if (!rst_n) begin
      win_l <= lsc_pkg::WIN_LEFT_RST;
      win_r <= lsc_pkg::WIN_RIGHT_RST;
      win_t <= lsc_pkg::WIN_TOP_RST;
      win_b <= lsc_pkg::WIN_BOTTOM_RST;
      clipped_q.delete();
      mismatches <= 0;
    end else begin
      if (in_tvalid && in_tready) clipped_q.push_back(clip_segment(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[11:0], out_tdata[23:12], out_tdata[35:24],
               out_tdata[47:36], out_tdata[51:48], out_tdata[55:52]};
        if (clipped_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected output beat %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = clipped_q.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display({"mismatch: exp vis=%0d (%0d,%0d)-(%0d,%0d) rs=%h re=%h,",
                        " got vis=%0d (%0d,%0d)-(%0d,%0d) rs=%h re=%h"},
                       want.visible, signed'(want.cxs), signed'(want.cys), signed'(want.cxe),
                       signed'(want.cye), want.rs, want.re, got.visible, signed'(got.cxs),
                       signed'(got.cys), signed'(got.cxe), signed'(got.cye), got.rs, got.re);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          lsc_pkg::REG_LEFT:   win_l <= sx12(cfg_pwdata[11:0]);
          lsc_pkg::REG_RIGHT:  win_r <= sx12(cfg_pwdata[11:0]);
          lsc_pkg::REG_TOP:    win_t <= sx12(cfg_pwdata[11:0]);
          lsc_pkg::REG_BOTTOM: win_b <= sx12(cfg_pwdata[11:0]);
          default: ;
        endcase
      end
    end
    pending = clipped_q.size();
  end
endmodule

// ===== tb/sv/tb_line_segment_clip.sv =====
// Testbench top for the line segment clipper: stimulus, flow control and verdict.
module tb_line_segment_clip;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0, out_tuser;
  logic [47:0] in_tdata = '0;
  logic [55:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  int mismatches, pending;
  int tx_idle = 0, rx_idle = 0, hold_go = 0, hold_cnt = 0, stuck = 0;
  int seg_count = 0;
  int lo_x, hi_x, lo_y, hi_y;

  always #10 clk = ~clk;

  line_segment_clip uut (.*);

  line_segment_clip_checker chk (.*);

  // receiver flow control; a requested hold keeps tready low for a long stretch
  always @(negedge clk) begin
    if (hold_go != 0) begin
      hold_cnt = 300;
      hold_go = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 3000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic set_window(int l, int r, int t, int b);
    write_reg(lsc_pkg::REG_LEFT, l);
    write_reg(lsc_pkg::REG_RIGHT, r);
    write_reg(lsc_pkg::REG_TOP, t);
    write_reg(lsc_pkg::REG_BOTTOM, b);
    lo_x = (l < r ? l : r) - 300; hi_x = (l < r ? r : l) + 300;
    lo_y = (t < b ? t : b) - 300; hi_y = (t < b ? b : t) + 300;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_seg(int xs, int ys, int xe, int ye);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {12'(ye), 12'(xe), 12'(ys), 12'(xs)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    seg_count++;
  endtask

  function automatic int coord(int lo, int hi);
    int v;
    if ($urandom_range(9) < 2) return int'($urandom_range(4095)) - 2048;
    v = lo + int'($urandom_range(hi - lo));
    return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: default window 200..400
    send_seg(300, 300, 350, 350);
    send_seg(100, 300, 500, 300);
    send_seg(300, 100, 300, 500);
    send_seg(100, 100, 150, 500);
    send_seg(100, 100, 500, 500);
    send_seg(500, 100, 100, 500);
    send_seg(150, 150, 250, 180);
    send_seg(150, 250, 450, 150);
    send_seg(450, 450, 250, 150);
    send_seg(100, 450, 300, 150);
    send_seg(-2048, -2048, 2047, 2047);
    send_seg(2047, -2048, -2048, 2047);
    send_seg(-2048, 2047, -2048, -2048);
    send_seg(2047, 2047, 2047, 2047);
    send_seg(200, 200, 400, 400);
    send_seg(199, 190, 410, 405);
    send_seg(0, 0, 0, 0);
    send_seg(100, 150, 420, 380);
    drain();
    set_window(-2048, 2047, -2048, 2047);
    send_seg(-2048, -2048, 2047, 2047);
    send_seg(-1, -1, 0, 0);
    drain();
    set_window(0, 0, 0, 0);
    send_seg(-5, -5, 5, 5);
    send_seg(-5, 0, 5, 0);
    drain();
    set_window(400, 200, 400, 200);
    send_seg(300, 300, 500, 100);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(lsc_pkg::WIN_LEFT_RST, lsc_pkg::WIN_RIGHT_RST,
                      lsc_pkg::WIN_TOP_RST, lsc_pkg::WIN_BOTTOM_RST);
        1: set_window(-2048, 2047, -2048, 2047);
        2: set_window(-300, 250, -100, 600);
        3: set_window(500, -100, 300, 100);
        4: set_window(2000, 2047, -2048, -1990);
        default: set_window(-700, 900, -1500, 1200);
      endcase
      tx_idle = ph < 2 ? 32 : (ph < 4 ? 65 : 0);
      rx_idle = ph < 2 ? 65 : (ph < 4 ? 32 : 0);
      for (int i = 0; i < 330; i++) begin
        if (ph == 4 && i == 50) hold_go = 1;
        if (ph == 2 && i == 100) drain();
        send_seg(coord(lo_x, hi_x), coord(lo_y, hi_y), coord(lo_x, hi_x), coord(lo_y, hi_y));
      end
      drain();
    end
    $display("Sent %0d segments over ten window settings (default, full, point, inverted,",
             seg_count);
    $display("edge-hugging, random) with sender and receiver stalls and a long output hold.");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
